### rtl/core/btpc_pkg.sv
// ----------------------------------------------------------------------------
// btpc_pkg
// Shared types and constants of the barometric compensation block.
// ----------------------------------------------------------------------------
package btpc_pkg;

  typedef struct packed {
    logic [19:0] raw_temperature;
    logic [19:0] raw_pressure;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] temperature;
    logic signed [31:0] fine_temperature;
    logic [31:0]        pressure;
    logic               pressure_invalid;
  } out_item_t;

  // handoff from front (temperature, dividend, divisor) to back (divide, finish)
  typedef struct packed {
    logic [31:0] tfine;
    logic [31:0] temp;
    logic [63:0] num;
    logic [63:0] den;
  } job_t;

  localparam logic [1:0] REG_TEMP    = 2'd0;
  localparam logic [1:0] REG_PLOW    = 2'd1;
  localparam logic [1:0] REG_PHIGH   = 2'd2;
  localparam logic [1:0] REG_PNINE   = 2'd3;
  localparam int unsigned CFG_IDX_W  = 8;

  localparam logic [63:0] TFINE_OFFSET = 64'd128000;
  localparam logic [63:0] PRESS_FULL   = 64'd1048576;
  localparam logic [63:0] PRESS_SCALE  = 64'd3125;

endpackage

### rtl/core/btpc_front.sv
// ----------------------------------------------------------------------------
// btpc_front
// Temperature compensation and pressure dividend/divisor, pipelined stages.
// One item may enter every cycle; wide products are split over stages.
// ----------------------------------------------------------------------------
module btpc_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_vld,
  input  btpc_pkg::in_item_t in_item,
  input  logic [47:0]        temp_coeffs,
  input  logic [63:0]        press_lo,
  input  logic [63:0]        press_hi,
  output logic               job_vld,
  output btpc_pkg::job_t     job
);

  localparam int NST = 7;

  logic [NST-1:0] vld_r;

  // stage 1
  logic [31:0] a_r, b_r;
  logic [19:0] p1_adc_r;
  // stage 2
  logic [31:0] ta_r, bb_r;
  logic [19:0] p2_adc_r;
  // stage 3
  logic [31:0] tfine_r;
  logic [19:0] p3_adc_r;
  // stage 4: v1 fits in 33 signed bits
  logic signed [32:0] v1_r, v1v1_lo_r;
  logic [31:0] tfine4_r, temp4_r;
  logic [19:0] p4_adc_r;
  // stage 5
  logic [63:0] v1v1_r, v1p5_r, v1p2_r;
  logic [31:0] tfine5_r, temp5_r;
  logic [19:0] p5_adc_r;
  // stage 6
  logic [63:0] v2_r, x1_r;
  logic [31:0] tfine6_r, temp6_r;
  logic [19:0] p6_adc_r;
  // stage 7
  logic [63:0] num_r, den_r;
  logic [31:0] tfine7_r, temp7_r;

  logic [31:0] t1, t2, t3, adc_t;
  logic [63:0] p1, p2, p3, p4, p5, p6;
  logic [31:0] tb_w, tfine_w, temp_w;
  logic [63:0] v1_w, hi_w, dp_w, sum47_w;
  logic [63:0] prod_w;

  assign adc_t = {12'd0, in_item.raw_temperature};
  assign t1 = {16'd0, temp_coeffs[15:0]};
  assign t2 = {{16{temp_coeffs[31]}}, temp_coeffs[31:16]};
  assign t3 = {{16{temp_coeffs[47]}}, temp_coeffs[47:32]};
  assign p1 = {48'd0, press_lo[15:0]};
  assign p2 = {{48{press_lo[31]}}, press_lo[31:16]};
  assign p3 = {{48{press_lo[47]}}, press_lo[47:32]};
  assign p4 = {{48{press_lo[63]}}, press_lo[63:48]};
  assign p5 = {{48{press_hi[15]}}, press_hi[15:0]};
  assign p6 = {{48{press_hi[31]}}, press_hi[31:16]};

  // temperature and pressure combinational pieces
  assign tb_w    = 32'($signed(bb_r) >>> 12) * t3;
  assign tfine_w = ta_r + 32'($signed(tb_w) >>> 14);
  assign temp_w  = 32'($signed(tfine_r * 32'd5 + 32'd128) >>> 8);
  assign v1_w    = {{32{tfine_r[31]}}, tfine_r} - btpc_pkg::TFINE_OFFSET;
  assign sum47_w = (64'd1 << 47) + x1_r;
  assign prod_w  = sum47_w * p1;
  assign dp_w    = ((btpc_pkg::PRESS_FULL - {44'd0, p6_adc_r}) << 31) - v2_r;
  assign hi_w    = 64'($signed(prod_w) >>> 33);

  // advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[NST-2:0], in_vld};
    end
  end

  // datapath stages
  always_ff @(posedge clk) begin
    a_r      <= (adc_t >> 3) - (t1 << 1);
    b_r      <= (adc_t >> 4) - t1;
    p1_adc_r <= in_item.raw_pressure;

    ta_r     <= 32'($signed(a_r * t2) >>> 11);
    bb_r     <= b_r * b_r;
    p2_adc_r <= p1_adc_r;

    tfine_r  <= tfine_w;
    p3_adc_r <= p2_adc_r;

    v1_r      <= v1_w[32:0];
    v1v1_lo_r <= v1_w[32:0];
    tfine4_r  <= tfine_r;
    temp4_r   <= temp_w;
    p4_adc_r  <= p3_adc_r;

    v1v1_r   <= v1_r * v1v1_lo_r;
    v1p5_r   <= v1_r * $signed(p5);
    v1p2_r   <= v1_r * $signed(p2);
    tfine5_r <= tfine4_r;
    temp5_r  <= temp4_r;
    p5_adc_r <= p4_adc_r;

    v2_r     <= v1v1_r * p6 + (v1p5_r << 17) + (p4 << 35);
    x1_r     <= 64'($signed(v1v1_r * p3) >>> 8) + (v1p2_r << 12);
    tfine6_r <= tfine5_r;
    temp6_r  <= temp5_r;
    p6_adc_r <= p5_adc_r;

    num_r    <= dp_w * btpc_pkg::PRESS_SCALE;
    den_r    <= hi_w;
    tfine7_r <= tfine6_r;
    temp7_r  <= temp6_r;
  end

  assign job_vld   = vld_r[NST-1];
  assign job.tfine = tfine7_r;
  assign job.temp  = temp7_r;
  assign job.num   = num_r;
  assign job.den   = den_r;

endmodule

### rtl/core/btpc_queue.sv
// ----------------------------------------------------------------------------
// btpc_queue
// Short job queue between the front pipeline and the divider back end.
// ----------------------------------------------------------------------------
module btpc_queue #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_vld,
  input  btpc_pkg::job_t wr_job,
  input  logic           rd_take,
  output logic           rd_vld,
  output btpc_pkg::job_t rd_job,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  btpc_pkg::job_t       mem_r [DEPTH];
  logic [AW-1:0]        wp_r, rp_r;
  logic [$clog2(DEPTH+1)-1:0] cnt_r;

  // hold entries, advance pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_vld) wp_r <= (wp_r == AW'(DEPTH-1)) ? '0 : wp_r + 1'b1;
      if (rd_take) rp_r <= (rp_r == AW'(DEPTH-1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (wr_vld ? 1'b1 : 1'b0) - (rd_take ? 1'b1 : 1'b0);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_vld) mem_r[wp_r] <= wr_job;
  end

  assign rd_vld = (cnt_r != '0);
  assign rd_job = mem_r[rp_r];
  assign count  = cnt_r;

endmodule

### rtl/core/btpc_back.sv
// ----------------------------------------------------------------------------
// btpc_back
// Signed 64-bit radix-2 divider (one quotient bit per cycle) and the final
// pressure correction stages.
// ----------------------------------------------------------------------------
module btpc_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                job_vld,
  input  btpc_pkg::job_t      job,
  output logic                job_take,
  input  logic [63:0]         press_hi,
  input  logic [15:0]         p9_raw,
  output logic                out_valid,
  output btpc_pkg::out_item_t out_item
);

  logic        busy_r;
  logic [6:0]  cnt_r;
  logic [63:0] rem_r, quo_r, md_r;
  logic        neg_r, inv_r;
  logic [31:0] tfine_r, temp_r;
  // finish stages
  logic [3:0]  fv_r;
  logic [63:0] p_r, ps_r, w2_r, pp_r, sql_r, w1_r, pp3_r, w2b_r;
  logic [31:0] sqx_r;
  logic        inv1_r, inv2_r, inv3_r;
  logic [31:0] tf1_r, tf2_r, tf3_r, tm1_r, tm2_r, tm3_r;

  logic [63:0] p7, p8, p9, mn_w, md_w, rsh_w, q_w, sq_w;
  logic [64:0] trial_w;

  assign p7 = {{48{press_hi[47]}}, press_hi[47:32]};
  assign p8 = {{48{press_hi[63]}}, press_hi[63:48]};
  assign p9 = {{48{p9_raw[15]}}, p9_raw};
  assign mn_w = job.num[63] ? (64'd0 - job.num) : job.num;
  assign md_w = job.den[63] ? (64'd0 - job.den) : job.den;
  assign rsh_w = {rem_r[62:0], quo_r[63]};
  assign trial_w = {1'b0, rsh_w} - {1'b0, md_r};
  assign q_w = neg_r ? (64'd0 - quo_r) : quo_r;
  // ps*ps modulo 2^64 from the low square and the cross product
  assign sq_w = sql_r + {sqx_r[30:0], 33'd0};

  assign job_take = job_vld && !busy_r;

  // iterate one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (job_take) begin
      busy_r <= 1'b1;
      cnt_r  <= 7'd64;
    end else if (busy_r) begin
      cnt_r  <= cnt_r - 7'd1;
      if (cnt_r == 7'd0) busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (job_take) begin
      rem_r   <= '0;
      quo_r   <= mn_w;
      md_r    <= md_w;
      neg_r   <= job.num[63] ^ job.den[63];
      inv_r   <= (job.den == 64'd0);
      tfine_r <= job.tfine;
      temp_r  <= job.temp;
    end else if (busy_r && cnt_r != 7'd0) begin
      if (!trial_w[64]) begin
        rem_r <= trial_w[63:0];
        quo_r <= {quo_r[62:0], 1'b1};
      end else begin
        rem_r <= rsh_w;
        quo_r <= {quo_r[62:0], 1'b0};
      end
    end
  end

  // finish: ps*ps*p9 and p8*p over registered stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= '0;
    end else begin
      fv_r <= {fv_r[2:0], busy_r && cnt_r == 7'd0};
    end
  end

  always_ff @(posedge clk) begin
    p_r    <= q_w;
    ps_r   <= 64'($signed(q_w) >>> 13);
    inv1_r <= inv_r;
    tf1_r  <= tfine_r;
    tm1_r  <= temp_r;

    sql_r  <= {32'd0, ps_r[31:0]} * {32'd0, ps_r[31:0]};
    sqx_r  <= ps_r[31:0] * ps_r[63:32];
    w2_r   <= 64'($signed(p8 * p_r) >>> 19);
    pp_r   <= p_r;
    inv2_r <= inv1_r;
    tf2_r  <= tf1_r;
    tm2_r  <= tm1_r;

    w1_r   <= 64'($signed(p9 * sq_w) >>> 25);
    pp3_r  <= pp_r;
    w2b_r  <= w2_r;
    inv3_r <= inv2_r;
    tf3_r  <= tf2_r;
    tm3_r  <= tm2_r;

    if (inv3_r) begin
      out_item.pressure <= '0;
    end else begin
      out_item.pressure <= 32'(64'($signed(pp3_r + w1_r + w2b_r) >>> 8) + (p7 << 4));
    end
    out_item.pressure_invalid <= inv3_r;
    out_item.temperature      <= tm3_r;
    out_item.fine_temperature <= tf3_r;
  end

  assign out_valid = fv_r[3];

endmodule

### rtl/core/baro_temp_press_compensation.sv
// ----------------------------------------------------------------------------
// baro_temp_press_compensation
// Temperature and pressure compensation from raw readings and calibration.
// ----------------------------------------------------------------------------
// One result per accepted item, shown for one cycle on out_valid; the receiver
// cannot stall. The front pipeline takes an item every cycle while busy is low,
// but the back end runs a radix-2 divider at one quotient bit per cycle and takes
// a new job only after the last one has left the divider; start is refused (busy
// high) while QDEPTH items sit in the front pipeline and the job queue together.
// A result passes the 7 front stages, the job queue, the divider and the finish
// stages.
module baro_temp_press_compensation #(
  parameter int QDEPTH = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  btpc_pkg::in_item_t  in_item,
  output logic                out_valid,
  output btpc_pkg::out_item_t out_item,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [btpc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]         cfg_data
);

  logic [47:0] temp_r;
  logic [63:0] plo_r, phi_r;
  logic [15:0] p9_r;
  logic [$clog2(QDEPTH+1)-1:0] qcnt;
  logic [3:0]  inflight_r;
  logic        acc, fj_vld, q_vld, q_take;
  btpc_pkg::job_t fj, qj;

  assign cfg_ready = 1'b1;
  assign acc = start && !busy;
  // hold off when queued plus in-flight front items could overflow queue
  assign busy = (32'(qcnt) + 32'(inflight_r)) >= QDEPTH;

  // write calibration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_r <= '0;
      plo_r  <= '0;
      phi_r  <= '0;
      p9_r   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        8'(btpc_pkg::REG_TEMP):  temp_r <= cfg_data[47:0];
        8'(btpc_pkg::REG_PLOW):  plo_r  <= cfg_data;
        8'(btpc_pkg::REG_PHIGH): phi_r  <= cfg_data;
        8'(btpc_pkg::REG_PNINE): p9_r   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // count items inside the front pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inflight_r <= '0;
    end else begin
      inflight_r <= inflight_r + (acc ? 4'd1 : 4'd0) - (fj_vld ? 4'd1 : 4'd0);
    end
  end

  btpc_front u_front (
    .clk(clk), .rst_n(rst_n), .in_vld(acc), .in_item(in_item),
    .temp_coeffs(temp_r), .press_lo(plo_r), .press_hi(phi_r),
    .job_vld(fj_vld), .job(fj)
  );

  btpc_queue #(.DEPTH(QDEPTH)) u_queue (
    .clk(clk), .rst_n(rst_n), .wr_vld(fj_vld), .wr_job(fj),
    .rd_take(q_take), .rd_vld(q_vld), .rd_job(qj), .count(qcnt)
  );

  btpc_back u_back (
    .clk(clk), .rst_n(rst_n), .job_vld(q_vld), .job(qj), .job_take(q_take),
    .press_hi(phi_r), .p9_raw(p9_r), .out_valid(out_valid), .out_item(out_item)
  );

endmodule

### tb/sv/baro_temp_press_compensation_checker.sv
// ----------------------------------------------------------------------------
// baro_temp_press_compensation_checker
// Watches the item, result and calibration channels, predicts each result and
// compares it field by field with what the block produces.
// ----------------------------------------------------------------------------
module baro_temp_press_compensation_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                busy,
  input  btpc_pkg::in_item_t  in_item,
  input  logic                out_valid,
  input  btpc_pkg::out_item_t out_item,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [btpc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]         cfg_data,
  output int                  errors,
  output int                  pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // calibration copy, all zero after reset
  logic [47:0] temp_cal;
  logic [63:0] press_cal_lo;
  logic [63:0] press_cal_hi;
  logic [15:0] press_cal_nine;

  btpc_pkg::out_item_t readings_due[$];

  function automatic logic signed [63:0] sext16(logic [15:0] v);
    logic signed [63:0] r;
    r = {{48{v[15]}}, v};
    return r;
  endfunction

  // signed 64-bit quotient, truncated toward zero, wrapping on overflow
  function automatic logic signed [63:0] quot_trunc(logic signed [63:0] num,
                                                    logic signed [63:0] den);
    logic [63:0] mn;
    logic [63:0] md;
    logic [63:0] q;
    mn = num[63] ? -num : num;
    md = den[63] ? -den : den;
    q  = mn / md;
    return (num[63] != den[63]) ? -q : q;
  endfunction

  function automatic btpc_pkg::out_item_t compensate(btpc_pkg::in_item_t it);
    btpc_pkg::out_item_t r;
    logic signed [31:0] t1, t2, t3, a, b, ta, tb, tf, tmp;
    logic signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic signed [63:0] v1, v2, p, ps, w1, w2;
    t1 = {16'b0, temp_cal[15:0]};
    t2 = {{16{temp_cal[31]}}, temp_cal[31:16]};
    t3 = {{16{temp_cal[47]}}, temp_cal[47:32]};
    p1 = {48'b0, press_cal_lo[15:0]};
    p2 = sext16(press_cal_lo[31:16]);
    p3 = sext16(press_cal_lo[47:32]);
    p4 = sext16(press_cal_lo[63:48]);
    p5 = sext16(press_cal_hi[15:0]);
    p6 = sext16(press_cal_hi[31:16]);
    p7 = sext16(press_cal_hi[47:32]);
    p8 = sext16(press_cal_hi[63:48]);
    p9 = sext16(press_cal_nine);

    // temperature path, 32-bit wrap
    a   = {15'b0, it.raw_temperature[19:3]} - (t1 <<< 1);
    ta  = (a * t2) >>> 11;
    b   = {16'b0, it.raw_temperature[19:4]} - t1;
    tb  = (((b * b) >>> 12) * t3) >>> 14;
    tf  = ta + tb;
    tmp = (tf * 32'sd5 + 32'sd128) >>> 8;

    // pressure path, 64-bit wrap
    v1 = tf;
    v1 = v1 - 64'sd128000;
    v2 = v1 * v1 * p6;
    v2 = v2 + ((v1 * p5) <<< 17);
    v2 = v2 + (p4 <<< 35);
    v1 = ((v1 * v1 * p3) >>> 8) + ((v1 * p2) <<< 12);
    v1 = (((64'sd1 <<< 47) + v1) * p1) >>> 33;

    r.temperature      = tmp;
    r.fine_temperature = tf;
    r.pressure         = '0;
    r.pressure_invalid = 1'b1;
    if (v1 != 0) begin
      p  = 64'sd1048576 - $signed({44'b0, it.raw_pressure});
      p  = ((p <<< 31) - v2) * 64'sd3125;
      p  = quot_trunc(p, v1);
      ps = p >>> 13;
      w1 = (p9 * ps * ps) >>> 25;
      w2 = (p8 * p) >>> 19;
      p  = ((p + w1 + w2) >>> 8) + (p7 <<< 4);
      r.pressure         = p[31:0];
      r.pressure_invalid = 1'b0;
    end
    return r;
  endfunction

  assign pending = readings_due.size();

  always @(posedge clk) begin
    btpc_pkg::out_item_t exp_r;
    int nerr;
    nerr = 0;
    if (!rst_n) begin
      temp_cal       <= '0;
      press_cal_lo   <= '0;
      press_cal_hi   <= '0;
      press_cal_nine <= '0;
      errors         <= 0;
    end else begin
      // compare the result beat with the oldest prediction
      if (out_valid) begin
        if (readings_due.size() == 0) begin
          $error("result beat with nothing expected");
          nerr++;
        end else begin
          exp_r = readings_due.pop_front();
          if (out_item.temperature !== exp_r.temperature) begin
            $error("temperature: expected %0d, got %0d",
                   exp_r.temperature, out_item.temperature);
            nerr++;
          end
          if (out_item.fine_temperature !== exp_r.fine_temperature) begin
            $error("fine_temperature: expected %0d, got %0d",
                   exp_r.fine_temperature, out_item.fine_temperature);
            nerr++;
          end
          if (out_item.pressure !== exp_r.pressure) begin
            $error("pressure: expected %h, got %h", exp_r.pressure, out_item.pressure);
            nerr++;
          end
          if (out_item.pressure_invalid !== exp_r.pressure_invalid) begin
            $error("pressure_invalid: expected %b, got %b",
                   exp_r.pressure_invalid, out_item.pressure_invalid);
            nerr++;
          end
        end
      end
      errors <= errors + nerr;
      // predict each accepted item beat
      if (start && !busy) readings_due.push_back(compensate(in_item));
      // track calibration writes; unknown indexes are dropped
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          8'(btpc_pkg::REG_TEMP):  temp_cal       <= cfg_data[47:0];
          8'(btpc_pkg::REG_PLOW):  press_cal_lo   <= cfg_data;
          8'(btpc_pkg::REG_PHIGH): press_cal_hi   <= cfg_data;
          8'(btpc_pkg::REG_PNINE): press_cal_nine <= cfg_data[15:0];
          default: ;
        endcase
      end
    end
  end

endmodule

### tb/sv/tb_baro_temp_press_compensation.sv
// ----------------------------------------------------------------------------
// tb_baro_temp_press_compensation
// Drives raw readings and calibration sets into the compensation block under
// varying sender gaps; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_baro_temp_press_compensation;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IW = btpc_pkg::CFG_IDX_W;
  localparam logic [IW-1:0] IDX_TEMP   = IW'(btpc_pkg::REG_TEMP);
  localparam logic [IW-1:0] IDX_PLOW   = IW'(btpc_pkg::REG_PLOW);
  localparam logic [IW-1:0] IDX_PHIGH  = IW'(btpc_pkg::REG_PHIGH);
  localparam logic [IW-1:0] IDX_PNINE  = IW'(btpc_pkg::REG_PNINE);
  localparam logic [IW-1:0] REG_UNUSED = 8'd200;
  localparam int DRAIN_CYCLES = 100;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  btpc_pkg::in_item_t in_item = '0;
  logic out_valid;
  btpc_pkg::out_item_t out_item;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [IW-1:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;
  int errors;
  int pending;
  int gap_pct;
  int sent;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  baro_temp_press_compensation dut (
    .clk, .rst_n, .start, .busy, .in_item, .out_valid, .out_item,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  baro_temp_press_compensation_checker u_checker (
    .clk, .rst_n, .start, .busy, .in_item, .out_valid, .out_item,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data, .errors, .pending
  );

  // hold the item until the block takes it, then maybe leave a gap
  task automatic send_reading(logic [19:0] rt, logic [19:0] rp);
    logic took;
    start   <= 1'b1;
    in_item <= '{raw_temperature: rt, raw_pressure: rp};
    do begin
      @(negedge clk);
      took = !busy;
      @(posedge clk);
    end while (!took);
    sent++;
    if ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  task automatic write_cal(logic [IW-1:0] idx, logic [63:0] data);
    logic took;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do begin
      @(negedge clk);
      took = cfg_ready;
      @(posedge clk);
    end while (!took);
    cfg_valid <= 1'b0;
  endtask

  // let the block go quiet before touching calibration
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_coeff();
    case ($urandom_range(5))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h7FFF;
      3: return 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [19:0] pick_raw();
    case ($urandom_range(7))
      0: return 20'h00000;
      1: return 20'hFFFFF;
      2: return 20'h80000;
      3: return 20'h7FFFF;
      default: return 20'($urandom);
    endcase
  endfunction

  // load one calibration set; kind selects typical, extreme or random content
  task automatic load_cal(int kind);
    case (kind)
      0: begin
        write_cal(IDX_TEMP,  {16'hFFFF, 16'(-16'sd1000), 16'd26435, 16'd27504});
        write_cal(IDX_PLOW,  {16'd2855, 16'd3024, 16'(-16'sd10685), 16'd36477});
        write_cal(IDX_PHIGH, {16'(-16'sd14600), 16'd15500, 16'(-16'sd7), 16'd140});
        write_cal(IDX_PNINE, 64'd6000);
      end
      1: begin
        write_cal(IDX_TEMP,  '1);
        write_cal(IDX_PLOW,  '1);
        write_cal(IDX_PHIGH, '1);
        write_cal(IDX_PNINE, '1);
      end
      2: begin
        write_cal(IDX_TEMP,  64'h0000_7FFF_7FFF_FFFF);
        write_cal(IDX_PLOW,  64'h8000_7FFF_8000_FFFF);
        write_cal(IDX_PHIGH, 64'h7FFF_8000_7FFF_8000);
        write_cal(IDX_PNINE, 64'h0000_0000_0000_8000);
      end
      3: begin
        write_cal(IDX_TEMP,  64'h0);
        write_cal(IDX_PLOW,  64'h0);
        write_cal(IDX_PHIGH, 64'h0);
        write_cal(IDX_PNINE, 64'h7FFF);
      end
      default: begin
        write_cal(IDX_TEMP,  {$urandom, $urandom});
        write_cal(IDX_PLOW,  {pick_coeff(), pick_coeff(), pick_coeff(), pick_coeff()});
        write_cal(IDX_PHIGH, {pick_coeff(), pick_coeff(), pick_coeff(), pick_coeff()});
        write_cal(IDX_PNINE, {$urandom, $urandom});
      end
    endcase
  endtask

  initial begin
    gap_pct = 9;
    sent = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset calibration: divisor is zero for every reading
    send_reading(20'h00000, 20'h00000);
    send_reading(20'hFFFFF, 20'hFFFFF);
    drain();

    // typical calibration, field extremes
    load_cal(0);
    write_cal(REG_UNUSED, '1);
    send_reading(20'h00000, 20'h00000);
    send_reading(20'hFFFFF, 20'hFFFFF);
    send_reading(20'h00000, 20'hFFFFF);
    send_reading(20'hFFFFF, 20'h00000);
    send_reading(20'h80000, 20'h80000);
    send_reading(20'h7FFFF, 20'h7FFFF);
    send_reading(20'h82000, 20'h51000);
    send_reading(20'h7E000, 20'h65000);
    drain();
    load_cal(1);
    send_reading(20'h00000, 20'h00000);
    send_reading(20'hFFFFF, 20'hFFFFF);
    send_reading(20'h82000, 20'h51000);
    drain();
    load_cal(2);
    send_reading(20'h00000, 20'hFFFFF);
    send_reading(20'hFFFFF, 20'h00000);
    send_reading(20'h12345, 20'h6789A);
    drain();

    // random phases over changing calibration and sender gaps
    sent = 0;
    for (int ph = 0; ph < 10; ph++) begin
      load_cal((ph < 3) ? ph : ((ph == 5) ? 3 : 4));
      for (int i = 0; i < 125; i++) begin
        gap_pct = (sent < 420) ? 9 : ((sent < 840) ? 83 : 0);
        if ($urandom_range(3) == 0)
          send_reading(pick_raw(), pick_raw());
        else
          send_reading(20'($urandom), 20'($urandom));
        // hold off once until the block has emptied
        if (ph == 4 && i == 60) begin
          start <= 1'b0;
          @(posedge clk);
          while (pending != 0) @(posedge clk);
        end
      end
      drain();
    end

    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule
